@@ rtl/rcpdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpdq_pkg: shared definitions for the RC pulse decoder and quad mixer
// Widths, register indexes, reset values and the divider handshake types.
// ----------------------------------------------------------------------------
package rcpdq_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int TICK_W     = 16;
  localparam int STICK_W    = 10;
  localparam int MOTOR_W    = 12;
  localparam int MIX_W      = 14;
  localparam int DIVIDEND_W = 26;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_STEPS  = 13;  // two quotient bits per step
  localparam int DIV_CNT_W  = 4;

  localparam logic [STICK_W-1:0] STICK_FULL = 10'd1000;
  localparam logic [MIX_W-1:0]   STICK_MID  = 14'd500;

  localparam logic [CH_W-1:0] CH_ROLL     = 2'd0;
  localparam logic [CH_W-1:0] CH_PITCH    = 2'd1;
  localparam logic [CH_W-1:0] CH_THROTTLE = 2'd2;
  localparam logic [CH_W-1:0] CH_YAW      = 2'd3;

  localparam logic [1:0] REG_PULSE_MIN  = 2'd0;
  localparam logic [1:0] REG_PULSE_MAX  = 2'd1;
  localparam logic [1:0] REG_MOTOR_LOW  = 2'd2;
  localparam logic [1:0] REG_MOTOR_HIGH = 2'd3;

  localparam logic [TICK_W-1:0]  PULSE_MIN_RST  = 16'd2140;
  localparam logic [TICK_W-1:0]  PULSE_MAX_RST  = 16'd3862;
  localparam logic [MOTOR_W-1:0] MOTOR_LOW_RST  = 12'd1000;
  localparam logic [MOTOR_W-1:0] MOTOR_HIGH_RST = 12'd2000;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/rcpdq_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpdq_div: iterative unsigned divider
// Restoring radix-4 division, two quotient bits per cycle over DIV_STEPS
// steps. done pulses for one cycle once the quotient is final.
// ----------------------------------------------------------------------------
module rcpdq_div import rcpdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  den_r;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;

  // Partial remainders of the two sub-steps.
  logic [DIVISOR_W:0]    t1, t2;
  logic [DIVISOR_W-1:0]  r1, r2;
  logic                  q1, q2;

  always_comb begin
    t1 = {rem_r, dq_r[DIVIDEND_W-1]};
    q1 = (t1 >= {1'b0, den_r});
    r1 = q1 ? DIVISOR_W'(t1 - {1'b0, den_r}) : t1[DIVISOR_W-1:0];
    t2 = {r1, dq_r[DIVIDEND_W-2]};
    q2 = (t2 >= {1'b0, den_r});
    r2 = q2 ? DIVISOR_W'(t2 - {1'b0, den_r}) : t2[DIVISOR_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = req.dividend;
    end else if (busy_r) begin
      rem_nxt = r2;
      dq_nxt  = {dq_r[DIVIDEND_W-3:0], q1, q2};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    if (req.start) begin
      den_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

@@ rtl/rcpdq_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpdq_mix: quad-X motor mixer
// Forms the four motor sums from the stick values and clamps each one,
// high limit first and low limit second.
// ----------------------------------------------------------------------------
module rcpdq_mix import rcpdq_pkg::*; (
  input  logic [STICK_W-1:0] roll,
  input  logic [STICK_W-1:0] pitch,
  input  logic [STICK_W-1:0] throttle,
  input  logic [STICK_W-1:0] yaw,
  input  logic [MOTOR_W-1:0] low_limit,
  input  logic [MOTOR_W-1:0] high_limit,
  output logic [MOTOR_W-1:0] motor_front_a,
  output logic [MOTOR_W-1:0] motor_front_b,
  output logic [MOTOR_W-1:0] motor_rear_a,
  output logic [MOTOR_W-1:0] motor_rear_b
);

  logic signed [MIX_W-1:0] base, r, p, y, lo, hi;
  logic signed [MIX_W-1:0] s0, s1, s2, s3;

  function automatic logic [MOTOR_W-1:0] clamp(input logic signed [MIX_W-1:0] s,
                                               input logic signed [MIX_W-1:0] lo_v,
                                               input logic signed [MIX_W-1:0] hi_v);
    logic signed [MIX_W-1:0] v;
    v = (s >= hi_v) ? hi_v : s;
    v = (v <= lo_v) ? lo_v : v;
    return v[MOTOR_W-1:0];
  endfunction

  always_comb begin
    lo   = signed'({{(MIX_W-MOTOR_W){1'b0}}, low_limit});
    hi   = signed'({{(MIX_W-MOTOR_W){1'b0}}, high_limit});
    base = lo + signed'({{(MIX_W-STICK_W){1'b0}}, throttle});
    r    = signed'({{(MIX_W-STICK_W){1'b0}}, roll}  - STICK_MID);
    p    = signed'({{(MIX_W-STICK_W){1'b0}}, pitch} - STICK_MID);
    y    = signed'({{(MIX_W-STICK_W){1'b0}}, yaw}   - STICK_MID);
    s0   = base + r + p + y;
    s1   = base + r - p - y;
    s2   = base - r - p + y;
    s3   = base - r + p - y;
    motor_front_a = clamp(s0, lo, hi);
    motor_front_b = clamp(s1, lo, hi);
    motor_rear_a  = clamp(s2, lo, hi);
    motor_rear_b  = clamp(s3, lo, hi);
  end

endmodule

@@ rtl/rc_pulse_decode_quad_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_decode_quad_mixer: RC capture decoder with quad-X motor mixer
// Pairs rising and falling captures per channel, maps pulse widths to stick
// values through a shared iterative divider and mixes four motor commands.
// ----------------------------------------------------------------------------
//  Channel | Ports                | Word contents
//  --------+----------------------+---------------------------------------
//  in      | in_tvalid/tready     | tdata: capture_count; tuser: channel
//  out     | out_tvalid/tready    | tdata: four motors; tuser: edge flags
//  cfg     | cfg_we/addr/wdata    | register index 0..3, 16-bit data
//
// A rising capture, or a falling one with an empty tick window, goes from
// idle straight to the mix state. A falling capture passes through the
// multiply state, 13 radix-4 divider steps, the done pulse and the mix state.
// in_tready is high only while the sequencer is idle; a finished word waits
// in the output register without holding off the next capture.
// Reset is synchronous active low and restores all register defaults.
// ----------------------------------------------------------------------------
module rc_pulse_decode_quad_mixer import rcpdq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] capture_count, [23:16] zero
  input  logic [1:0]  in_tuser,   // [1:0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [11:0] motor_front_a, [23:12] motor_front_b,
                                  // [35:24] motor_rear_a, [47:36] motor_rear_b
  output logic [1:0]  out_tuser,  // [0] edge_was_rising, [1] value_accepted
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_MIX  = 2'd3;

  logic [1:0]         state_r, state_nxt;

  logic [TICK_W-1:0]  pulse_min_r, pulse_max_r;
  logic [MOTOR_W-1:0] motor_low_r, motor_high_r;

  logic [TICK_W-1:0]  rise_time_r [CHANNELS];
  logic [CHANNELS-1:0] awaiting_r;
  logic [STICK_W-1:0] stick_r [CHANNELS];

  logic [CH_W-1:0]    ch_r;
  logic [TICK_W-1:0]  width_r;
  logic               ge_r;
  logic               rising_r, accepted_r;

  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic [1:0]         out_user_r;

  logic               in_acc, out_free, load_out;
  logic [CH_W-1:0]    in_ch;
  logic [TICK_W-1:0]  in_cap;
  logic               width_ge;
  logic [TICK_W-1:0]  mag;
  logic [DIVIDEND_W-1:0] product;
  logic               q_ok;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [MOTOR_W-1:0] m_fa, m_fb, m_ra, m_rb;

  assign in_ch    = in_tuser;
  assign in_cap   = in_tdata[TICK_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign load_out = (state_r == ST_MIX) && out_free;

  // Magnitude of the offset from the window start, scaled by full stick.
  always_comb begin
    width_ge = (width_r >= pulse_min_r);
    mag      = width_ge ? (width_r - pulse_min_r) : (pulse_min_r - width_r);
    product  = DIVIDEND_W'(mag) * DIVIDEND_W'(STICK_FULL);
  end

  assign div_req.start    = (state_r == ST_MUL);
  assign div_req.dividend = product;
  assign div_req.divisor  = pulse_max_r - pulse_min_r;

  // A short pulse is only kept when it truncates to zero.
  assign q_ok = ge_r ? (div_rsp.quotient <= DIVIDEND_W'(STICK_FULL))
                     : (div_rsp.quotient == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!awaiting_r[in_ch] || (pulse_max_r <= pulse_min_r)) begin
            state_nxt = ST_MIX;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pulse_min_r  <= PULSE_MIN_RST;
      pulse_max_r  <= PULSE_MAX_RST;
      motor_low_r  <= MOTOR_LOW_RST;
      motor_high_r <= MOTOR_HIGH_RST;
      awaiting_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time_r[i] <= '0;
        stick_r[i]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_PULSE_MIN:  pulse_min_r  <= cfg_wdata;
          REG_PULSE_MAX:  pulse_max_r  <= cfg_wdata;
          REG_MOTOR_LOW:  motor_low_r  <= cfg_wdata[MOTOR_W-1:0];
          REG_MOTOR_HIGH: motor_high_r <= cfg_wdata[MOTOR_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        awaiting_r[in_ch] <= !awaiting_r[in_ch];
        if (!awaiting_r[in_ch]) begin
          rise_time_r[in_ch] <= in_cap;
        end
      end
      if ((state_r == ST_DIV) && div_rsp.done && q_ok) begin
        stick_r[ch_r] <= ge_r ? div_rsp.quotient[STICK_W-1:0] : '0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r       <= in_ch;
      width_r    <= in_cap - rise_time_r[in_ch];
      rising_r   <= !awaiting_r[in_ch];
      accepted_r <= 1'b0;
    end
    if (state_r == ST_MUL) begin
      ge_r <= width_ge;
    end
    if ((state_r == ST_DIV) && div_rsp.done) begin
      accepted_r <= q_ok;
    end
    if (load_out) begin
      out_data_r <= {m_rb, m_ra, m_fb, m_fa};
      out_user_r <= {accepted_r, rising_r};
    end
  end

  rcpdq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rcpdq_mix u_mix (
    .roll          (stick_r[CH_ROLL]),
    .pitch         (stick_r[CH_PITCH]),
    .throttle      (stick_r[CH_THROTTLE]),
    .yaw           (stick_r[CH_YAW]),
    .low_limit     (motor_low_r),
    .high_limit    (motor_high_r),
    .motor_front_a (m_fa),
    .motor_front_b (m_fb),
    .motor_rear_a  (m_ra),
    .motor_rear_b  (m_rb)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
